@@ rtl/rf_dimmer_frame_encoder_core_assert.svh @@
// Assertion macros for the dimmer frame encoder core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RF_DIMMER_FRAME_ENCODER_CORE_ASSERT_SVH
`define RF_DIMMER_FRAME_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RFDE_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfde assertion failed");
`define RFDE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfde assertion failed");
`else
`define RFDE_ASSERT_SAME(name, ante, cons)
`define RFDE_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/rfde_pkg.sv @@
`timescale 1ns / 1ps

package rfde_pkg;

  // Symbol codes
  localparam logic [1:0] SymStart = 2'd0;
  localparam logic [1:0] SymOne   = 2'd1;
  localparam logic [1:0] SymZero  = 2'd2;
  localparam logic [1:0] SymEnd   = 2'd3;

  // Command codes
  localparam logic [1:0] FuncOn    = 2'd0;
  localparam logic [1:0] FuncOff   = 2'd1;
  localparam logic [1:0] FuncDim   = 2'd2;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSystemNumber = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgUnitMask     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSmoothFade   = 2'd2;
  localparam int CfgDataW = 10;

  // Frame layout: start, 14 address bits, 2 parity, 6 level bits, 2 parity, end
  localparam int AddrW     = 14;
  localparam int LevelW    = 6;
  localparam int FrameBits = AddrW + 2 + LevelW + 2;
  localparam int FrameLen  = FrameBits + 2;
  localparam int IdxW      = $clog2(FrameLen);

  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic       is_last;
  } out_item_t;

  typedef logic [FrameBits-1:0] frame_bits_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

endpackage

@@ rtl/rfde_front.sv @@
`timescale 1ns / 1ps

module rfde_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rfde_pkg::in_item_t                  in_item,
  input  logic                                cfg_valid,
  input  logic [rfde_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [rfde_pkg::CfgDataW-1:0]       cfg_data,
  input  rfde_pkg::q_stat_t                   q_stat,
  output logic                                q_push,
  output rfde_pkg::frame_bits_t               q_wdata
);

  localparam logic [7:0] QOffMax  = 8'd12;
  localparam logic [7:0] QFullMax = 8'd237;
  localparam logic [7:0] QBase    = 8'd38;
  localparam logic [7:0] QStep    = 8'd25;
  localparam logic [3:0] QCodeOff = 4'd10;
  localparam logic [3:0] QCodeFull = 4'd0;
  localparam logic [1:0] FadeSmooth  = 2'b11;
  localparam logic [1:0] FadeInstant = 2'b01;
  localparam logic [rfde_pkg::AddrW-1:0] AddrOddMask  = 14'h2AAA;
  localparam logic [rfde_pkg::AddrW-1:0] AddrEvenMask = 14'h1555;
  localparam logic [rfde_pkg::LevelW-1:0] LvlEvenMask = 6'h15;
  localparam logic [rfde_pkg::LevelW-1:0] LvlOddMask  = 6'h2A;

  logic [3:0] system_number_r, system_number_nxt;
  logic [9:0] unit_mask_r, unit_mask_nxt;
  logic       smooth_fade_r, smooth_fade_nxt;

  logic [7:0]                    lv;
  logic [3:0]                    qcode;
  logic                          cmd_ok;
  logic [rfde_pkg::AddrW-1:0]    addr;
  logic [rfde_pkg::LevelW-1:0]   lword;
  logic [rfde_pkg::LevelW-1:0]   lword_rev;

  function automatic logic [3:0] quantize(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd1;
    for (int k = 0; k < 8; k++) begin
      if (v >= QBase + 8'(k) * QStep) c = c + 4'd1;
    end
    if (v <= QOffMax) c = QCodeOff;
    else if (v > QFullMax) c = QCodeFull;
    return c;
  endfunction

  always_comb begin
    system_number_nxt = system_number_r;
    unit_mask_nxt     = unit_mask_r;
    smooth_fade_nxt   = smooth_fade_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rfde_pkg::CfgSystemNumber: system_number_nxt = cfg_data[3:0];
        rfde_pkg::CfgUnitMask:     unit_mask_nxt     = cfg_data;
        rfde_pkg::CfgSmoothFade:   smooth_fade_nxt   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      system_number_r <= '0;
      unit_mask_r     <= '0;
      smooth_fade_r   <= 1'b1;
    end else begin
      system_number_r <= system_number_nxt;
      unit_mask_r     <= unit_mask_nxt;
      smooth_fade_r   <= smooth_fade_nxt;
    end
  end

  // classify the command and build the frame bits, first symbol in the MSB
  always_comb begin
    cmd_ok = 1'b1;
    unique case (in_item.func)
      rfde_pkg::FuncOn:  lv = 8'd255;
      rfde_pkg::FuncOff: lv = 8'd0;
      rfde_pkg::FuncDim: lv = in_item.level;
      default: begin
        lv     = 8'd0;
        cmd_ok = 1'b0;
      end
    endcase
    qcode = quantize(lv);
    addr  = {system_number_r, unit_mask_r};
    lword = {(smooth_fade_r ? FadeSmooth : FadeInstant), qcode};
    for (int i = 0; i < rfde_pkg::LevelW; i++) begin
      lword_rev[rfde_pkg::LevelW-1-i] = lword[i];
    end
    q_wdata = {addr,
               ~^(addr & AddrOddMask), ~^(addr & AddrEvenMask),
               lword_rev,
               ~^(lword & LvlEvenMask), ~^(lword & LvlOddMask)};
  end

  assign in_stall = q_stat.full;
  // drop unsupported commands and frames with no addressed unit
  assign q_push   = in_valid && !q_stat.full && cmd_ok && (unit_mask_r != '0);

endmodule

@@ rtl/rfde_fifo.sv @@
`timescale 1ns / 1ps

module rfde_fifo #(
  parameter int WIDTH = rfde_pkg::FrameBits,
  parameter int DEPTH = rfde_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              pop,
  output logic [WIDTH-1:0]  rdata,
  output rfde_pkg::q_stat_t stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full     = (cnt_r == CntW'(DEPTH));
  assign stat.nonempty = (cnt_r != '0);
  assign do_push = push && !stat.full;
  assign do_pop  = pop && stat.nonempty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

@@ rtl/rfde_back.sv @@
`timescale 1ns / 1ps

module rfde_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rfde_pkg::q_stat_t     q_stat,
  input  rfde_pkg::frame_bits_t q_rdata,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rfde_pkg::out_item_t   out_item
);

  localparam logic [rfde_pkg::IdxW-1:0] IdxLast = rfde_pkg::IdxW'(rfde_pkg::FrameLen - 1);

  logic                         active_r, active_nxt;
  logic [rfde_pkg::IdxW-1:0]    idx_r, idx_nxt;
  rfde_pkg::frame_bits_t        bits_r, bits_nxt;
  logic                         out_valid_r, out_valid_nxt;
  rfde_pkg::out_item_t          out_item_r, out_item_nxt;
  rfde_pkg::out_item_t          sym;
  logic                         adv, emit, last, load;

  assign adv  = !out_valid_r || !out_stall;
  assign emit = active_r && adv;
  assign last = (idx_r == IdxLast);
  assign load = q_stat.nonempty && (!active_r || (emit && last));
  assign q_pop = load;

  always_comb begin
    sym.is_last = 1'b0;
    if (idx_r == '0) begin
      sym.symbol = rfde_pkg::SymStart;
    end else if (last) begin
      sym.symbol  = rfde_pkg::SymEnd;
      sym.is_last = 1'b1;
    end else begin
      sym.symbol = bits_r[rfde_pkg::FrameBits-1] ? rfde_pkg::SymOne : rfde_pkg::SymZero;
    end
  end

  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    bits_nxt      = bits_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (adv) begin
      out_valid_nxt = active_r;
      out_item_nxt  = sym;
    end
    if (emit) begin
      idx_nxt = idx_r + 1'b1;
      // advance the bit line once the start symbol has gone
      if (idx_r != '0) bits_nxt = {bits_r[rfde_pkg::FrameBits-2:0], 1'b0};
      if (last) active_nxt = 1'b0;
    end
    if (load) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      bits_nxt   = q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r     <= bits_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/rf_dimmer_frame_encoder_core.sv @@
`timescale 1ns / 1ps
// Radio dimmer frame encoder. Each accepted command (on, off, dim) becomes one
// frame of 26 symbols on the out channel, one symbol per cycle while out_stall
// is low, the terminator flagged with is_last. Unsupported commands, and any
// command while unit_mask is zero, are dropped without output. Commands are
// classified on entry and queued (QDEPTH frames); the symbol sequencer drains
// the queue at one symbol per cycle while out_stall is low, so the sustained
// command rate is set by the frame length. Configuration writes are always
// accepted (cfg_ready tied high) and apply to commands taken after the write.
`include "rf_dimmer_frame_encoder_core_assert.svh"

module rf_dimmer_frame_encoder_core #(
  parameter int QDEPTH = rfde_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rfde_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rfde_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfde_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rfde_pkg::CfgDataW-1:0] cfg_data
);

  rfde_pkg::q_stat_t     q_stat;
  logic                  q_push, q_pop;
  rfde_pkg::frame_bits_t q_wdata, q_rdata;
  logic                  out_take;
  logic                  out_is_start;
  logic                  out_is_end;
  logic                  out_is_bit;

  assign cfg_ready = 1'b1;

  rfde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  rfde_fifo #(
    .WIDTH (rfde_pkg::FrameBits),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  rfde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_take     = out_valid && !out_stall;
  assign out_is_start = (out_item.symbol == rfde_pkg::SymStart);
  assign out_is_end   = (out_item.symbol == rfde_pkg::SymEnd);
  assign out_is_bit   = (out_item.symbol == rfde_pkg::SymOne) ||
                        (out_item.symbol == rfde_pkg::SymZero);

  `RFDE_ASSERT_SAME(a_last_is_end, out_valid && out_item.is_last, out_is_end)
  `RFDE_ASSERT_SAME(a_end_is_last, out_valid && out_is_end, out_item.is_last)
  `RFDE_ASSERT_NEXT(a_start_then_bit, out_take && out_is_start, !out_valid || out_is_bit)
  `RFDE_ASSERT_SAME(a_pop_nonempty, q_pop, q_stat.nonempty)

endmodule

@@ test/rf_dimmer_frame_encoder_core_tb.sv @@
`timescale 1ns / 1ps

module rf_dimmer_frame_encoder_core_tb;

  localparam logic [1:0] FuncUnsup = 2'd3;
  localparam int IdlePct = 22;
  localparam int DrainCycles = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  rfde_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  rfde_pkg::out_item_t           out_item;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rfde_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [rfde_pkg::CfgDataW-1:0] cfg_data = '0;

  // Shadow copy of the configuration registers
  logic [3:0] sys_code = 4'd0;
  logic [9:0] unit_bits = 10'd0;
  logic       fade_smooth = 1'b1;

  rfde_pkg::out_item_t pending_symbols[$];
  int                  bad_symbols = 0;
  int                  hold_len = 0;
  bit                  jitter_on = 1'b1;

  rf_dimmer_frame_encoder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void push_symbol(logic [1:0] sym, logic last);
    rfde_pkg::out_item_t s;
    s.symbol  = sym;
    s.is_last = last;
    pending_symbols.push_back(s);
  endfunction

  // Queue the symbols of the frame that one command should produce.
  function automatic void encode_command(rfde_pkg::in_item_t cmd);
    logic [7:0]  lv;
    logic [3:0]  code;
    logic [13:0] addr;
    logic [5:0]  lvl_word;
    int          odd_ones;
    int          even_ones;
    case (cmd.func)
      rfde_pkg::FuncOn:  lv = 8'd255;
      rfde_pkg::FuncOff: lv = 8'd0;
      rfde_pkg::FuncDim: lv = cmd.level;
      default: return;
    endcase
    if (unit_bits == 10'd0) return;

    push_symbol(rfde_pkg::SymStart, 1'b0);
    addr = {sys_code, unit_bits};
    odd_ones = 0;
    even_ones = 0;
    for (int i = rfde_pkg::AddrW - 1; i >= 0; i--) begin
      if (addr[i]) begin
        push_symbol(rfde_pkg::SymOne, 1'b0);
        if (i % 2 == 1) odd_ones++;
        else even_ones++;
      end else begin
        push_symbol(rfde_pkg::SymZero, 1'b0);
      end
    end
    push_symbol(odd_ones[0] ? rfde_pkg::SymZero : rfde_pkg::SymOne, 1'b0);
    push_symbol(even_ones[0] ? rfde_pkg::SymZero : rfde_pkg::SymOne, 1'b0);

    if (lv <= 8'd12) code = 4'd10;
    else if (lv > 8'd237) code = 4'd0;
    else code = 4'((int'(lv) - 13) / 25 + 1);
    lvl_word = {fade_smooth ? 2'b11 : 2'b01, code};
    odd_ones = 0;
    even_ones = 0;
    for (int i = 0; i < rfde_pkg::LevelW; i++) begin
      if (lvl_word[i]) begin
        push_symbol(rfde_pkg::SymOne, 1'b0);
        if (i % 2 == 1) odd_ones++;
        else even_ones++;
      end else begin
        push_symbol(rfde_pkg::SymZero, 1'b0);
      end
    end
    push_symbol(even_ones[0] ? rfde_pkg::SymZero : rfde_pkg::SymOne, 1'b0);
    push_symbol(odd_ones[0] ? rfde_pkg::SymZero : rfde_pkg::SymOne, 1'b0);
    push_symbol(rfde_pkg::SymEnd, 1'b1);
  endfunction

  // Track config writes, predict on accepted commands, then check results.
  always @(posedge clk) begin
    rfde_pkg::out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rfde_pkg::CfgSystemNumber: sys_code = cfg_data[3:0];
          rfde_pkg::CfgUnitMask:     unit_bits = cfg_data[9:0];
          rfde_pkg::CfgSmoothFade:   fade_smooth = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) encode_command(in_item);
      if (out_valid && !out_stall) begin
        if (pending_symbols.size() == 0) begin
          bad_symbols++;
          if (bad_symbols <= 10)
            $display("unexpected symbol %0d is_last %0d", out_item.symbol, out_item.is_last);
        end else begin
          want = pending_symbols.pop_front();
          if (out_item.symbol !== want.symbol || out_item.is_last !== want.is_last) begin
            bad_symbols++;
            if (bad_symbols <= 10)
              $display("mismatch: symbol exp %0d got %0d, is_last exp %0d got %0d",
                       want.symbol, out_item.symbol, want.is_last, out_item.is_last);
          end
        end
      end
    end
  end

  // Receiver side: long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      out_stall <= jitter_on && ($urandom_range(99) < IdlePct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // in_valid still high so back-to-back transactions stay clean.
  task automatic send_command(input logic [1:0] func, input logic [7:0] level);
    while (jitter_on && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_item.func  <= func;
    in_item.level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every queued symbol, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [3:0] sys, input logic [9:0] mask,
                                input logic smooth, input logic [9:0] junk);
    logic [rfde_pkg::CfgIdxW-1:0]  idx [3];
    logic [rfde_pkg::CfgDataW-1:0] dat [3];
    idx[0] = rfde_pkg::CfgSystemNumber;
    dat[0] = {junk[5:0], sys};
    idx[1] = rfde_pkg::CfgUnitMask;
    dat[1] = mask;
    idx[2] = rfde_pkg::CfgSmoothFade;
    dat[2] = {junk[8:0], smooth};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_mask();
    send_command(rfde_pkg::FuncOn, 8'd0);
    send_command(rfde_pkg::FuncOff, 8'd255);
    send_command(rfde_pkg::FuncDim, 8'd128);
    send_command(FuncUnsup, 8'd7);
    settle();
  endtask

  task automatic test_directed_frames();
    apply_settings(4'd15, 10'd1023, 1'b1, 10'd0);
    send_command(rfde_pkg::FuncOn, 8'd0);
    send_command(rfde_pkg::FuncOff, 8'd255);
    send_command(rfde_pkg::FuncDim, 8'd0);
    send_command(rfde_pkg::FuncDim, 8'd12);
    send_command(rfde_pkg::FuncDim, 8'd13);
    send_command(rfde_pkg::FuncDim, 8'd37);
    send_command(rfde_pkg::FuncDim, 8'd38);
    send_command(rfde_pkg::FuncDim, 8'd237);
    send_command(rfde_pkg::FuncDim, 8'd238);
    send_command(rfde_pkg::FuncDim, 8'd255);
    send_command(FuncUnsup, 8'd255);
    settle();
    apply_settings(4'd0, 10'd1, 1'b0, 10'd0);
    send_command(rfde_pkg::FuncOn, 8'd85);
    send_command(rfde_pkg::FuncOff, 8'd170);
    send_command(rfde_pkg::FuncDim, 8'd170);
    send_command(FuncUnsup, 8'd0);
    settle();
    // alternating patterns hit both parity polarities
    apply_settings(4'd10, 10'h2AA, 1'b1, 10'd0);
    send_command(rfde_pkg::FuncDim, 8'd85);
    send_command(rfde_pkg::FuncDim, 8'd138);
    settle();
  endtask

  task automatic test_random_traffic(input int frame_goal);
    int         frames;
    int         count;
    logic [9:0] mask;
    logic [1:0] func;
    frames = 0;
    while (frames < frame_goal) begin
      case ($urandom_range(7))
        0:       mask = 10'd0;
        1:       mask = 10'd1023;
        2:       mask = 10'd1 << $urandom_range(9);
        default: mask = 10'($urandom_range(1023, 1));
      endcase
      apply_settings(4'($urandom_range(15)), mask, 1'($urandom_range(1)),
                     10'($urandom_range(1023)));
      count = $urandom_range(50, 20);
      repeat (count) begin
        func = ($urandom_range(9) == 0) ? FuncUnsup : 2'($urandom_range(2));
        send_command(func, 8'($urandom_range(255)));
        if (func != FuncUnsup && mask != 10'd0) frames++;
      end
      settle();
    end
  endtask

  task automatic test_quiet_stretch();
    jitter_on = 1'b0;
    apply_settings(4'($urandom_range(15)), 10'($urandom_range(1023, 1)), 1'b1, 10'd0);
    repeat (30) send_command(2'($urandom_range(2)), 8'($urandom_range(255)));
    settle();
    jitter_on = 1'b1;
  endtask

  task automatic test_backpressure();
    jitter_on = 1'b0;
    apply_settings(4'd5, 10'h155, 1'b0, 10'd0);
    // hold the receiver so the frame queue fills and stalls the sender
    hold_len = 300;
    repeat (20) send_command(2'($urandom_range(2)), 8'($urandom_range(255)));
    settle();
    jitter_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_mask();
    test_directed_frames();
    test_quiet_stretch();
    test_backpressure();
    test_random_traffic(130);
    settle();
    if (bad_symbols == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ rf_dimmer_frame_encoder_core.f @@
+incdir+rtl
rtl/rfde_pkg.sv
rtl/rfde_front.sv
rtl/rfde_fifo.sv
rtl/rfde_back.sv
rtl/rf_dimmer_frame_encoder_core.sv
test/rf_dimmer_frame_encoder_core_tb.sv
